/* src/sca_pkg.sv */
package sca_pkg;

   localparam int FREE_DEPTH = 1024;
   localparam int OFFSET_W   = 20;
   localparam int SPACE_W    = 21;
   localparam int NUM_CLASS  = 3;
   localparam int TOP_W      = $clog2(FREE_DEPTH + 1);
   localparam int IDX_W      = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
   localparam int MEM_DEPTH  = NUM_CLASS * FREE_DEPTH;
   localparam int MEM_AW     = $clog2(MEM_DEPTH);

   localparam logic [OFFSET_W-1:0] THREE_BASE_RST  = 20'd155556;
   localparam logic [OFFSET_W-1:0] FIVE_BASE_RST   = 20'd388887;
   localparam logic [SPACE_W-1:0]  TOTAL_SPACE_RST = 21'd777777;
   localparam logic [SPACE_W-1:0]  OFFSET_LIMIT    = 21'hFFFFF;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_INIT  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_BAD_SIZE  = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_THREE_BASE  = 2'd0,
      CSR_FIVE_BASE   = 2'd1,
      CSR_TOTAL_SPACE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CLS_TWO   = 2'd0,
      CLS_THREE = 2'd1,
      CLS_FIVE  = 2'd2
   } cls_type;

   typedef enum logic [2:0] {
      CMD_ALLOC,
      CMD_FREE,
      CMD_INIT,
      CMD_BAD_SIZE,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      cls_type               cls;
      logic [OFFSET_W-1:0]   offset;
   } cmd_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] three_base;
      logic [OFFSET_W-1:0] five_base;
      logic [SPACE_W-1:0]  total_space;
   } cfg_type;

   function automatic logic [2:0] class_size(input cls_type cls);
      logic [2:0] size;
      case (cls)
         CLS_TWO:   size = 3'd2;
         CLS_THREE: size = 3'd3;
         default:   size = 3'd5;
      endcase
      return size;
   endfunction

endpackage

/* src/sca_front.sv */
module sca_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_operation,
   input  logic [2:0]                    req_block_size,
   input  logic [sca_pkg::OFFSET_W-1:0]  req_free_offset,
   input  sca_pkg::cfg_type              cfg,
   output logic                          cmd_valid,
   output sca_pkg::cmd_type              cmd,
   input  logic                          cmd_pop
);
   import sca_pkg::*;

   cmd_type    classified;
   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok;

   // classify the request before it enters the command queue
   always_comb begin
      classified.kind   = CMD_NOP;
      classified.cls    = CLS_TWO;
      classified.offset = req_free_offset;
      case (req_operation)
         OP_ALLOC: begin
            classified.kind = CMD_ALLOC;
            case (req_block_size)
               3'd2:    classified.cls = CLS_TWO;
               3'd3:    classified.cls = CLS_THREE;
               3'd5:    classified.cls = CLS_FIVE;
               default: classified.kind = CMD_BAD_SIZE;
            endcase
         end
         OP_FREE: begin
            classified.kind = CMD_FREE;
            if (req_free_offset < cfg.three_base) begin
               classified.cls = CLS_TWO;
            end else if (req_free_offset < cfg.five_base) begin
               classified.cls = CLS_THREE;
            end else begin
               classified.cls = CLS_FIVE;
            end
         end
         OP_INIT: classified.kind = CMD_INIT;
         default: classified.kind = CMD_NOP;
      endcase
   end

   assign req_full  = (count_ff == 2'd2);
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (cmd_pop && cmd_valid) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push_ok && !(cmd_pop && cmd_valid)) begin
         count_in = count_ff + 2'd1;
      end else if (!push_ok && cmd_pop && cmd_valid) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

/* src/sca_back.sv */
module sca_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sca_pkg::cfg_type              cfg,
   input  logic                          cmd_valid,
   input  sca_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [sca_pkg::OFFSET_W-1:0]  rsp_granted_offset,
   output logic [1:0]                    rsp_status
);
   import sca_pkg::*;

   typedef enum logic [1:0] {
      BK_RUN  = 2'b01,
      BK_READ = 2'b10
   } bk_state_type;

   bk_state_type        state_ff, state_in;
   logic [TOP_W-1:0]    top_ff [NUM_CLASS];
   logic [TOP_W-1:0]    top_in [NUM_CLASS];
   logic [OFFSET_W-1:0] bump_ff [NUM_CLASS];
   logic [OFFSET_W-1:0] bump_in [NUM_CLASS];
   logic [OFFSET_W-1:0] mem [MEM_DEPTH];
   logic [OFFSET_W-1:0] rd_data_ff;
   logic                out_valid_ff, out_valid_in;
   logic [OFFSET_W-1:0] out_offset_ff, out_offset_in;
   status_type          out_status_ff, out_status_in;

   logic                take;
   logic                out_set;
   logic                rd_en, wr_en;
   logic [MEM_AW-1:0]   rd_addr, wr_addr;
   logic [TOP_W-1:0]    cur_top;
   logic [OFFSET_W-1:0] cur_bump;
   logic [SPACE_W-1:0]  bump_next;
   logic [SPACE_W-1:0]  region_end;
   logic [MEM_AW-1:0]   class_base;

   assign take    = (state_ff == BK_RUN) && cmd_valid && (!out_valid_ff || rsp_pop);
   assign cmd_pop = take;

   assign cur_top    = top_ff[cmd.cls];
   assign cur_bump   = bump_ff[cmd.cls];
   assign bump_next  = {1'b0, cur_bump} + SPACE_W'(class_size(cmd.cls));
   assign class_base = MEM_AW'(cmd.cls) * MEM_AW'(FREE_DEPTH);

   always_comb begin
      case (cmd.cls)
         CLS_TWO:   region_end = {1'b0, cfg.three_base};
         CLS_THREE: region_end = {1'b0, cfg.five_base};
         default:   region_end = cfg.total_space;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      top_in        = top_ff;
      bump_in       = bump_ff;
      out_set       = 1'b0;
      out_offset_in = '0;
      out_status_in = STATUS_OK;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      rd_addr       = class_base + MEM_AW'(IDX_W'(cur_top - TOP_W'(1)));
      wr_addr       = class_base + MEM_AW'(IDX_W'(cur_top));
      if (state_ff == BK_READ) begin
         out_set       = 1'b1;
         out_offset_in = rd_data_ff;
         state_in      = BK_RUN;
      end else if (take) begin
         case (cmd.kind)
            CMD_ALLOC: begin
               if (cur_top != '0) begin
                  // pop the free stack; data comes back next cycle
                  top_in[cmd.cls] = cur_top - TOP_W'(1);
                  rd_en           = 1'b1;
                  state_in        = BK_READ;
               end else if (bump_next > region_end || bump_next > OFFSET_LIMIT) begin
                  out_set       = 1'b1;
                  out_status_in = STATUS_EXHAUSTED;
               end else begin
                  out_set          = 1'b1;
                  out_offset_in    = cur_bump;
                  bump_in[cmd.cls] = bump_next[OFFSET_W-1:0];
               end
            end
            CMD_FREE: begin
               out_set = 1'b1;
               if (cur_top == TOP_W'(FREE_DEPTH)) begin
                  out_status_in = STATUS_FULL;
               end else begin
                  wr_en           = 1'b1;
                  top_in[cmd.cls] = cur_top + TOP_W'(1);
               end
            end
            CMD_INIT: begin
               out_set            = 1'b1;
               bump_in[CLS_TWO]   = '0;
               bump_in[CLS_THREE] = cfg.three_base;
               bump_in[CLS_FIVE]  = cfg.five_base;
               for (int i = 0; i < NUM_CLASS; i++) begin
                  top_in[i] = '0;
               end
            end
            CMD_BAD_SIZE: begin
               out_set       = 1'b1;
               out_status_in = STATUS_BAD_SIZE;
            end
            default: out_set = 1'b1;
         endcase
      end
   end

   always_comb begin
      if (out_set) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= BK_RUN;
         out_valid_ff       <= 1'b0;
         bump_ff[CLS_TWO]   <= '0;
         bump_ff[CLS_THREE] <= THREE_BASE_RST;
         bump_ff[CLS_FIVE]  <= FIVE_BASE_RST;
         for (int i = 0; i < NUM_CLASS; i++) begin
            top_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         bump_ff      <= bump_in;
         top_ff       <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_set) begin
         out_offset_ff <= out_offset_in;
         out_status_ff <= out_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= cmd.offset;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_granted_offset = out_offset_ff;
   assign rsp_status         = out_status_ff;

endmodule

/* src/size_class_room_allocator.sv */
// Size class allocator over one offset space with three regions (block
// sizes 2, 3 and 5), each with a bump pointer and a free stack.
// Requests come in through a queue-style port (req_push / req_full) with
// operation, block_size and free_offset; each request gives exactly one
// response (rsp_granted_offset, rsp_status) on a queue-style port
// (rsp_empty / rsp_pop), in request order.
// A two-entry command queue sits between the classifier and the executor.
// A request passes the command queue and the response register before
// rsp_empty falls; an allocate served from a free stack also passes the
// registered read of the stack memory. One request per cycle is taken
// while responses are popped, but none while a stack read is pending.
// If the receiver stalls, the response register holds and the command
// queue fills; req_full rises when it has no room.
// Region bounds are written on csr_* and should only change while idle.
// Reset restores the bounds, restarts the bump pointers and empties all
// stacks at once; no clearing pass is needed.
module size_class_room_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_operation,
   input  logic [2:0]                    req_block_size,
   input  logic [sca_pkg::OFFSET_W-1:0]  req_free_offset,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [sca_pkg::OFFSET_W-1:0]  rsp_granted_offset,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_write_en,
   input  logic [1:0]                    csr_index,
   input  logic [sca_pkg::SPACE_W-1:0]   csr_wdata
);
   import sca_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_THREE_BASE:  cfg_in.three_base  = csr_wdata[OFFSET_W-1:0];
            CSR_FIVE_BASE:   cfg_in.five_base   = csr_wdata[OFFSET_W-1:0];
            CSR_TOTAL_SPACE: cfg_in.total_space = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.three_base  <= THREE_BASE_RST;
         cfg_ff.five_base   <= FIVE_BASE_RST;
         cfg_ff.total_space <= TOTAL_SPACE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sca_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_operation   (req_operation),
      .req_block_size  (req_block_size),
      .req_free_offset (req_free_offset),
      .cfg             (cfg_ff),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   sca_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_status         (rsp_status)
   );

endmodule

/* test/size_class_room_allocator_tb.sv */
module size_class_room_allocator_tb;
   import sca_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]          op;
      logic [2:0]          size;
      logic [OFFSET_W-1:0] where;
   } request_type;

   typedef struct {
      logic [OFFSET_W-1:0] offset;
      logic [1:0]          status;
   } grant_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [1:0]          req_operation = '0;
   logic [2:0]          req_block_size = '0;
   logic [OFFSET_W-1:0] req_free_offset = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic [OFFSET_W-1:0] rsp_granted_offset;
   logic [1:0]          rsp_status;
   logic                csr_write_en = 1'b0;
   logic [1:0]          csr_index = '0;
   logic [SPACE_W-1:0]  csr_wdata = '0;

   // predictor copy of the bounds, bump pointers and free stacks
   logic [OFFSET_W-1:0] three_base = THREE_BASE_RST;
   logic [OFFSET_W-1:0] five_base  = FIVE_BASE_RST;
   logic [SPACE_W-1:0]  space_end  = TOTAL_SPACE_RST;
   logic [OFFSET_W-1:0] bump [3];
   logic [OFFSET_W-1:0] free_mem [3][FREE_DEPTH];
   int unsigned         stack_fill [3];

   logic [2:0]          valid_size [3] = '{3'd2, 3'd3, 3'd5};

   request_type         pending [$];
   grant_type           grants_due [$];
   logic [OFFSET_W-1:0] granted_pool [$];
   request_type         next_req;
   grant_type           due;
   int unsigned         queued = 0;
   int unsigned         accepted = 0;
   int unsigned         errors = 0;
   int unsigned         send_idle_max = 5;
   int unsigned         take_idle_max = 5;
   int                  send_wait = 0;
   int                  take_wait = 0;

   size_class_room_allocator dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_operation      (req_operation),
      .req_block_size     (req_block_size),
      .req_free_offset    (req_free_offset),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_status         (rsp_status),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic restart_classes();
      bump[CLS_TWO]   = '0;
      bump[CLS_THREE] = three_base;
      bump[CLS_FIVE]  = five_base;
      for (int c = 0; c < 3; c++) stack_fill[c] = 0;
   endtask

   task automatic predict_grant(input logic [1:0] op, input logic [2:0] size,
                                input logic [OFFSET_W-1:0] where);
      grant_type          g;
      cls_type            cls;
      bit                 sized;
      logic [SPACE_W-1:0] next_bump;
      logic [SPACE_W-1:0] region_end;
      g.offset = '0;
      g.status = STATUS_OK;
      cls = CLS_TWO;
      sized = 1'b1;
      if (op == OP_ALLOC) begin
         case (size)
            3'd2:    cls = CLS_TWO;
            3'd3:    cls = CLS_THREE;
            3'd5:    cls = CLS_FIVE;
            default: sized = 1'b0;
         endcase
         if (!sized) begin
            g.status = STATUS_BAD_SIZE;
         end else if (stack_fill[cls] > 0) begin
            stack_fill[cls]--;
            g.offset = free_mem[cls][stack_fill[cls]];
         end else begin
            next_bump = {1'b0, bump[cls]} + SPACE_W'(size);
            region_end = (cls == CLS_TWO)   ? {1'b0, three_base} :
                         (cls == CLS_THREE) ? {1'b0, five_base}  : space_end;
            // the advanced pointer must also stay within 20 bits
            if (next_bump > region_end || next_bump > OFFSET_LIMIT) begin
               g.status = STATUS_EXHAUSTED;
            end else begin
               g.offset = bump[cls];
               bump[cls] = next_bump[OFFSET_W-1:0];
            end
         end
         if (g.status == STATUS_OK) granted_pool.push_back(g.offset);
      end else if (op == OP_FREE) begin
         cls = (where < three_base) ? CLS_TWO : (where < five_base) ? CLS_THREE : CLS_FIVE;
         if (stack_fill[cls] >= FREE_DEPTH) begin
            g.status = STATUS_FULL;
         end else begin
            free_mem[cls][stack_fill[cls]] = where;
            stack_fill[cls]++;
         end
      end else if (op == OP_INIT) begin
         restart_classes();
         granted_pool.delete();
      end
      grants_due.push_back(g);
   endtask

   task automatic queue_request(input logic [1:0] op, input logic [2:0] size,
                                input logic [OFFSET_W-1:0] where);
      request_type r;
      r.op = op;
      r.size = size;
      r.where = where;
      pending.push_back(r);
      queued++;
   endtask

   task automatic drain();
      while (accepted != queued || grants_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_bound(input csr_index_type idx, input logic [SPACE_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_THREE_BASE:  three_base = value[OFFSET_W-1:0];
         CSR_FIVE_BASE:   five_base = value[OFFSET_W-1:0];
         CSR_TOTAL_SPACE: space_end = value;
         default:         ;
      endcase
   endtask

   // bounds only change with the block idle
   task automatic set_bounds(input logic [OFFSET_W-1:0] t, input logic [OFFSET_W-1:0] f,
                             input logic [SPACE_W-1:0] s);
      drain();
      write_bound(CSR_THREE_BASE, {1'b0, t});
      write_bound(CSR_FIVE_BASE, {1'b0, f});
      write_bound(CSR_TOTAL_SPACE, s);
      repeat (2) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_grant(req_operation, req_block_size, req_free_offset);
            accepted++;
         end
         if (!req_push || !req_full) begin
            if (send_wait > 0) begin
               send_wait--;
               req_push <= 1'b0;
            end else if (pending.size() != 0) begin
               next_req = pending.pop_front();
               req_push <= 1'b1;
               req_operation <= next_req.op;
               req_block_size <= next_req.size;
               req_free_offset <= next_req.where;
               send_wait = $urandom_range(0, send_idle_max);
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (grants_due.size() == 0) begin
               errors++;
               if (errors <= 100)
                  $display("%0t unexpected transfer: expected none actual offset %0d status %0d",
                           $time, rsp_granted_offset, rsp_status);
            end else begin
               due = grants_due.pop_front();
               if (rsp_granted_offset !== due.offset) begin
                  errors++;
                  if (errors <= 100)
                     $display("%0t granted_offset: expected %0d actual %0d",
                              $time, due.offset, rsp_granted_offset);
               end
               if (rsp_status !== due.status) begin
                  errors++;
                  if (errors <= 100)
                     $display("%0t status: expected %0d actual %0d",
                              $time, due.status, rsp_status);
               end
            end
            take_wait = $urandom_range(0, take_idle_max);
         end
         if (take_wait > 0) begin
            take_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      #1000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int                  pick;
      int                  slot;
      int                  mode;
      int unsigned         random_items;
      logic [OFFSET_W-1:0] t;
      logic [OFFSET_W-1:0] f;
      logic [SPACE_W-1:0]  s;
      logic [OFFSET_W-1:0] where;
      logic [2:0]          size;

      random_items = 0;
      restart_classes();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset bounds: first bump grants, bad sizes, boundary frees, unused op
      queue_request(OP_ALLOC, 3'd2, '0);
      queue_request(OP_ALLOC, 3'd3, 20'hFFFFF);
      queue_request(OP_ALLOC, 3'd5, '0);
      queue_request(OP_ALLOC, 3'd0, 20'hFFFFF);
      queue_request(OP_ALLOC, 3'd7, '0);
      queue_request(OP_FREE, 3'd7, '0);
      queue_request(OP_ALLOC, 3'd2, '0);
      queue_request(OP_FREE, 3'd0, THREE_BASE_RST - 20'd1);
      queue_request(OP_FREE, 3'd0, THREE_BASE_RST);
      queue_request(OP_FREE, 3'd0, FIVE_BASE_RST - 20'd1);
      queue_request(OP_FREE, 3'd0, FIVE_BASE_RST);
      queue_request(OP_FREE, 3'd0, 20'hFFFFF);
      queue_request(OP_ALLOC, 3'd5, '0);
      queue_request(OP_ALLOC, 3'd3, '0);
      queue_request(OP_UNUSED, 3'd7, 20'hFFFFF);
      queue_request(OP_INIT, 3'd0, '0);

      // tiny regions run out
      set_bounds(20'd4, 20'd10, 21'd15);
      queue_request(OP_INIT, 3'd0, '0);
      queue_request(OP_ALLOC, 3'd2, '0);
      queue_request(OP_ALLOC, 3'd2, '0);
      queue_request(OP_ALLOC, 3'd2, '0);
      queue_request(OP_ALLOC, 3'd5, '0);
      queue_request(OP_ALLOC, 3'd5, '0);

      // next bump would leave 20 bits; empty size-2 region
      set_bounds(20'd0, 20'd1048571, 21'd1048576);
      queue_request(OP_INIT, 3'd0, '0);
      queue_request(OP_ALLOC, 3'd5, '0);
      queue_request(OP_ALLOC, 3'd2, '0);

      // fill each free stack a little, then pop a few back in LIFO order
      set_bounds(THREE_BASE_RST, FIVE_BASE_RST, TOTAL_SPACE_RST);
      queue_request(OP_INIT, 3'd0, '0);
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < 10; i++) begin
            case (c)
               0:       where = 20'($urandom_range(0, THREE_BASE_RST - 1));
               1:       where = 20'($urandom_range(THREE_BASE_RST, FIVE_BASE_RST - 1));
               default: where = 20'($urandom_range(FIVE_BASE_RST, 20'hFFFFF));
            endcase
            size = 3'($urandom);
            queue_request(OP_FREE, size, where);
         end
         for (int i = 0; i < 6; i++) queue_request(OP_ALLOC, valid_size[c], 20'($urandom));
         for (int i = 0; i < 4; i++) begin
            case (c)
               0:       where = 20'($urandom_range(0, THREE_BASE_RST - 1));
               1:       where = 20'($urandom_range(THREE_BASE_RST, FIVE_BASE_RST - 1));
               default: where = 20'($urandom_range(FIVE_BASE_RST, 20'hFFFFF));
            endcase
            queue_request(OP_FREE, 3'($urandom), where);
         end
      end

      while (random_items < 600) begin
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            t = 20'($urandom_range(0, 40));
            f = 20'(t + $urandom_range(0, 60));
            s = 21'(f + $urandom_range(0, 100));
         end else if (mode < 8) begin
            t = 20'($urandom);
            f = 20'($urandom);
            s = 21'($urandom_range(0, 1048576));
         end else begin
            t = $urandom_range(0, 1) ? 20'hFFFFF : '0;
            f = $urandom_range(0, 1) ? 20'hFFFFF : '0;
            s = $urandom_range(0, 1) ? 21'd1048576 : '0;
         end
         set_bounds(t, f, s);
         send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
         take_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
         // without a restart the old bump pointers meet the new bounds
         if ($urandom_range(0, 3) != 0) queue_request(OP_INIT, 3'($urandom), 20'($urandom));
         for (int chunk = 0; chunk < 4; chunk++) begin
            while (pending.size() > 2) @(posedge clock);
            for (int i = 0; i < 20; i++) begin
               pick = $urandom_range(0, 99);
               size = 3'($urandom);
               where = $urandom_range(0, 1) ? 20'($urandom) : 20'($urandom_range(0, space_end));
               random_items++;
               if (pick < 45) begin
                  queue_request(OP_ALLOC, valid_size[$urandom_range(0, 2)], where);
               end else if (pick < 75 && granted_pool.size() > 0) begin
                  slot = $urandom_range(0, granted_pool.size() - 1);
                  queue_request(OP_FREE, size, granted_pool[slot]);
                  granted_pool.delete(slot);
               end else if (pick < 85) begin
                  queue_request(OP_FREE, size, where);
               end else if (pick < 93) begin
                  queue_request(OP_ALLOC, size, where);
               end else if (pick < 97) begin
                  queue_request(OP_INIT, size, where);
               end else begin
                  queue_request(OP_UNUSED, size, where);
                  random_items--;
               end
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (errors == 0 && grants_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
